// ===== rtl/swsb_pkg.sv =====
// Shared types and constants of the sliding window send buffer.
// Holds action and status codes, the pane row layout and the
// controller/datapath command and status structs. No dependencies.
package swsb_pkg;

  // Default number of panes.
  localparam int DEF_MAX_WINDOW = 256;

  // Remainder width of the modulo unit; the window size register is 9 bits.
  localparam int REM_W   = 10;
  localparam int DIGIT_W = 4;
  localparam int STEPS   = 32 / DIGIT_W;

  // Configuration register indexes.
  localparam logic REG_WINDOW_SIZE    = 1'b0;
  localparam logic REG_MAX_PACKET_LEN = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [8:0]  RST_WINDOW_SIZE = 9'd256;
  localparam logic [15:0] RST_MAX_LEN     = 16'd1500;

  // Action codes.
  localparam logic [2:0] ACT_ADD    = 3'd0;
  localparam logic [2:0] ACT_MARK   = 3'd1;
  localparam logic [2:0] ACT_CHECK  = 3'd2;
  localparam logic [2:0] ACT_SLIDE  = 3'd3;
  localparam logic [2:0] ACT_RESEND = 3'd4;

  // Status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RANGE    = 3'd1;
  localparam logic [2:0] ST_ORDER    = 3'd2;
  localparam logic [2:0] ST_BUSY     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  // Dividend source for the modulo unit.
  typedef enum logic [1:0] {
    SRC_CUR,
    SRC_SEQ,
    SRC_LOW
  } src_e;

  // One pane of the window table.
  typedef struct packed {
    logic [15:0] hdl;
    logic [15:0] len;
    logic [31:0] seq;
    logic        acked;
  } row_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic mod_start;
    src_e mod_src;
    logic slot_load;
    logic rd;
    logic open_load;
    logic exec;
    logic walk_step;
    logic low_commit;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mod_done;
    logic slide_go;
    logic walk_last;
  } sts_t;

endpackage

// ===== rtl/swsb_mod.sv =====
// Iterative modulo unit: 32-bit dividend modulo a window size.
// Retires four dividend bits per cycle. Depends on swsb_pkg.
module swsb_mod
  import swsb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [31:0]      dividend_i,
  input  logic [REM_W-1:0] divisor_i,
  output logic             done_o,
  output logic [REM_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(STEPS);

  logic [31:0]      dvd_q;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  // Four restoring steps per cycle on the narrow remainder.
  always_comb begin
    logic [REM_W-1:0] r, t;
    r = rem_q;
    for (int j = 0; j < DIGIT_W; j++) begin
      t = {r[REM_W-2:0], dvd_q[31-j]};
      if (t >= divisor_i) begin
        r = t - divisor_i;
      end else begin
        r = t;
      end
    end
    rem_d = r;
  end

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend and remainder.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[31-DIGIT_W:0], {DIGIT_W{1'b0}}};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/swsb_datapath.sv =====
// Datapath of the window: configuration, bounds, pane table and results.
// Executes controller commands. Depends on swsb_pkg and swsb_mod.
module swsb_datapath
  import swsb_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic [2:0]  action_i,
  input  logic [31:0] seq_num_i,
  input  logic [15:0] packet_len_i,
  input  logic [15:0] payload_handle_i,
  output logic [2:0]  status_o,
  output logic        ack_state_o,
  output logic [15:0] resend_len_o,
  output logic [15:0] resend_handle_o,
  output logic [31:0] lower_bound_o,
  output logic [31:0] next_seq_o,
  output logic        window_open_o
);

  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  // Configuration registers.
  logic [8:0]  ws_q;
  logic [15:0] maxlen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q     <= RST_WINDOW_SIZE;
      maxlen_q <= RST_MAX_LEN;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WINDOW_SIZE:    ws_q     <= cfg_data_i[8:0];
        REG_MAX_PACKET_LEN: maxlen_q <= cfg_data_i;
        default:            ws_q     <= ws_q;
      endcase
    end
  end

  // Effective window size, clamped to one and to the table depth.
  logic [REM_W-1:0] eff;
  always_comb begin
    if (ws_q == '0) begin
      eff = REM_W'(1);
    end else if (32'(ws_q) > MAX_WINDOW) begin
      eff = REM_W'(MAX_WINDOW);
    end else begin
      eff = REM_W'(ws_q);
    end
  end

  // Captured item.
  logic [2:0]  act_q;
  logic [31:0] seq_q;
  logic [15:0] len_q, hdl_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      act_q <= action_i;
      seq_q <= seq_num_i;
      len_q <= packet_len_i;
      hdl_q <= payload_handle_i;
    end
  end

  // Modulo unit and its dividend select.
  logic [31:0]      dvd;
  logic             mod_done;
  logic [REM_W-1:0] mod_rem;
  logic [31:0]      cur_q, low_q;

  always_comb begin
    unique case (cmd_i.mod_src)
      SRC_CUR: dvd = cur_q;
      SRC_SEQ: dvd = seq_q;
      SRC_LOW: dvd = low_q;
      default: dvd = cur_q;
    endcase
  end

  swsb_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mod_start),
    .dividend_i (dvd),
    .divisor_i  (eff),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // Pane table with a valid bit per row; a row never written reads as reset.
  row_t             mem [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] vld_q;
  row_t             rd_q;
  logic             rvld_q;
  logic [IDX_W-1:0] slot_q;
  logic             we;
  row_t             wrow;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[slot_q] <= wrow;
    end
    if (cmd_i.rd) begin
      rd_q <= mem[slot_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we) begin
        vld_q[slot_q] <= 1'b1;
      end
      if (cmd_i.rd) begin
        rvld_q <= vld_q[slot_q];
      end
    end
  end

  // Row as seen by the logic.
  logic        r_acked;
  logic [31:0] r_seq;
  logic [15:0] r_len;
  assign r_acked = rvld_q ? rd_q.acked : 1'b1;
  assign r_seq   = rvld_q ? rd_q.seq   : '0;
  assign r_len   = rvld_q ? rd_q.len   : '0;

  // Window tests.
  logic in_win, in_span, open_now, open_pre_q;
  assign in_win  = (seq_q >= low_q) &&
                   ({1'b0, seq_q} < ({1'b0, low_q} + 33'(eff)));
  assign in_span = (seq_q >= low_q) && (seq_q <= cur_q);
  assign open_now = ((cur_q - low_q) < 32'(eff)) && r_acked;

  // Action evaluation on the pane read for the item.
  logic [2:0]  ex_status;
  logic        ex_we, ex_inc, ex_ack;
  logic [15:0] ex_rlen, ex_rhdl;
  row_t        ex_row;
  logic [31:0] span;
  logic [REM_W-1:0] ex_n;

  assign span = seq_q - low_q;

  always_comb begin
    ex_status = ST_RANGE;
    ex_we     = 1'b0;
    ex_inc    = 1'b0;
    ex_ack    = 1'b0;
    ex_rlen   = '0;
    ex_rhdl   = '0;
    ex_row    = '{hdl: hdl_q, len: len_q, seq: seq_q, acked: 1'b0};
    ex_n      = (span < 32'(eff)) ? REM_W'(span) : eff;
    unique case (act_q)
      ACT_ADD: begin
        if (!open_pre_q || len_q == '0 || len_q > maxlen_q || !in_win) begin
          ex_status = ST_RANGE;
        end else if (seq_q != cur_q) begin
          ex_status = ST_ORDER;
        end else if (!r_acked) begin
          ex_status = ST_BUSY;
        end else begin
          ex_status = ST_OK;
          ex_we     = 1'b1;
          ex_inc    = 1'b1;
        end
      end
      ACT_MARK: begin
        if (!in_win) begin
          ex_status = ST_RANGE;
        end else if (r_seq != seq_q) begin
          ex_status = ST_NOTFOUND;
        end else begin
          ex_status = ST_OK;
          ex_we     = 1'b1;
          ex_row    = '{hdl: rd_q.hdl, len: r_len, seq: r_seq, acked: 1'b1};
        end
      end
      ACT_CHECK: begin
        if (!in_win) begin
          ex_status = ST_RANGE;
        end else if (r_seq != seq_q) begin
          ex_status = ST_NOTFOUND;
        end else begin
          ex_status = ST_OK;
          ex_ack    = r_acked;
        end
      end
      ACT_SLIDE: begin
        ex_status = in_span ? ST_OK : ST_RANGE;
      end
      ACT_RESEND: begin
        if (!in_span) begin
          ex_status = ST_RANGE;
        end else if (!r_acked && r_seq == seq_q) begin
          ex_status = ST_OK;
          ex_rlen   = r_len;
          ex_rhdl   = rd_q.hdl;
        end else begin
          ex_status = ST_NOTFOUND;
        end
      end
      default: ex_status = ST_RANGE;
    endcase
  end

  // Table write: item update or clearing of an acked pane during a slide.
  always_comb begin
    we   = 1'b0;
    wrow = ex_row;
    if (cmd_i.exec) begin
      we = ex_we;
    end else if (cmd_i.walk_step) begin
      we   = r_acked;
      wrow = '{hdl: rd_q.hdl, len: '0, seq: '0, acked: 1'b1};
    end
  end

  // Slot pointer and slide walk.
  logic [REM_W-1:0] n_q, wcnt_q;
  logic [IDX_W:0]   slot_inc;
  assign slot_inc = {1'b0, slot_q} + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.slot_load) begin
      slot_q <= IDX_W'(mod_rem);
    end else if (cmd_i.walk_step) begin
      slot_q <= (32'(slot_inc) == 32'(eff)) ? '0 : slot_inc[IDX_W-1:0];
    end
    if (cmd_i.exec) begin
      n_q    <= ex_n;
      wcnt_q <= '0;
    end else if (cmd_i.walk_step) begin
      wcnt_q <= wcnt_q + 1'b1;
    end
  end

  // Bounds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= 32'd1;
      low_q <= 32'd1;
    end else begin
      if (cmd_i.exec && ex_inc) begin
        cur_q <= cur_q + 32'd1;
      end
      if (cmd_i.low_commit) begin
        low_q <= seq_q;
      end
    end
  end

  // Per-item results and output register.
  logic [2:0]  st_q;
  logic        ack_q;
  logic [15:0] rlen_q, rhdl_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.open_load) begin
      open_pre_q <= open_now;
    end
    if (cmd_i.exec) begin
      st_q   <= ex_status;
      ack_q  <= ex_ack;
      rlen_q <= ex_rlen;
      rhdl_q <= ex_rhdl;
    end
    if (cmd_i.out_load) begin
      status_o        <= st_q;
      ack_state_o     <= ack_q;
      resend_len_o    <= rlen_q;
      resend_handle_o <= rhdl_q;
      lower_bound_o   <= low_q;
      next_seq_o      <= cur_q;
      window_open_o   <= open_now;
    end
  end

  // Status to the controller.
  assign sts_o.mod_done  = mod_done;
  assign sts_o.slide_go  = (act_q == ACT_SLIDE) && in_span && (span != '0);
  assign sts_o.walk_last = ((wcnt_q + 1'b1) == n_q);

endmodule

// ===== rtl/swsb_ctrl.sv =====
// Controller of the window: sequences modulo, table reads, action and walk.
// Drives the datapath through cmd_t. Depends on swsb_pkg.
module swsb_ctrl
  import swsb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_W_CUR, S_R_CUR, S_L_CUR, S_W_SEQ, S_R_SEQ, S_EXEC,
    S_W_LOW, S_WK_RD, S_WK_WR, S_POST, S_W_FIN, S_R_FIN, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q;
  logic   out_free;

  assign out_free = !out_vld_q || out_ready_i;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mod_src = SRC_CUR;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          cmd_o.mod_start = 1'b1;
          state_d = S_W_CUR;
        end
      end
      S_W_CUR: begin
        if (sts_i.mod_done) begin
          cmd_o.slot_load = 1'b1;
          state_d = S_R_CUR;
        end
      end
      S_R_CUR: begin
        cmd_o.rd = 1'b1;
        state_d = S_L_CUR;
      end
      S_L_CUR: begin
        cmd_o.open_load = 1'b1;
        cmd_o.mod_start = 1'b1;
        cmd_o.mod_src   = SRC_SEQ;
        state_d = S_W_SEQ;
      end
      S_W_SEQ: begin
        if (sts_i.mod_done) begin
          cmd_o.slot_load = 1'b1;
          state_d = S_R_SEQ;
        end
      end
      S_R_SEQ: begin
        cmd_o.rd = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.slide_go) begin
          cmd_o.mod_start = 1'b1;
          cmd_o.mod_src   = SRC_LOW;
          state_d = S_W_LOW;
        end else begin
          state_d = S_POST;
        end
      end
      S_W_LOW: begin
        if (sts_i.mod_done) begin
          cmd_o.slot_load = 1'b1;
          state_d = S_WK_RD;
        end
      end
      S_WK_RD: begin
        cmd_o.rd = 1'b1;
        state_d = S_WK_WR;
      end
      S_WK_WR: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.walk_last) begin
          cmd_o.low_commit = 1'b1;
          state_d = S_POST;
        end else begin
          state_d = S_WK_RD;
        end
      end
      S_POST: begin
        cmd_o.mod_start = 1'b1;
        state_d = S_W_FIN;
      end
      S_W_FIN: begin
        if (sts_i.mod_done) begin
          cmd_o.slot_load = 1'b1;
          state_d = S_R_FIN;
        end
      end
      S_R_FIN: begin
        cmd_o.rd = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;

endmodule

// ===== rtl/sliding_window_send_buffer.sv =====
// Sliding window send buffer: sender-side selective-repeat pane table.
// Each item takes three modulo operations in the 4-bit-per-cycle unit; a slide that clears
// n panes (n at most the window size) adds a fourth and a read and a walk step per pane.
// One item at a time; a new beat is taken while the last result waits.
// Reset: bounds to one, all panes acked and empty, registers to 256 and 1500.
module sliding_window_send_buffer
  import swsb_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [31:0] seq_num_i,
  input  logic [15:0] packet_len_i,
  input  logic [15:0] payload_handle_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic        ack_state_o,
  output logic [15:0] resend_len_o,
  output logic [15:0] resend_handle_o,
  output logic [31:0] lower_bound_o,
  output logic [31:0] next_seq_o,
  output logic        window_open_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  swsb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Table, bounds and result registers.
  swsb_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .action_i         (action_i),
    .seq_num_i        (seq_num_i),
    .packet_len_i     (packet_len_i),
    .payload_handle_i (payload_handle_i),
    .status_o         (status_o),
    .ack_state_o      (ack_state_o),
    .resend_len_o     (resend_len_o),
    .resend_handle_o  (resend_handle_o),
    .lower_bound_o    (lower_bound_o),
    .next_seq_o       (next_seq_o),
    .window_open_o    (window_open_o)
  );

endmodule
